[hw/rtl/bda_pkg.sv]
// ----------------------------------------------------------------------------
// bda_pkg
// Shared types and constants for the button debouncer with auto-repeat.
// ----------------------------------------------------------------------------
package bda_pkg;

  localparam int unsigned AgeW  = 16;
  localparam int unsigned WordW = 11;

  localparam logic [AgeW-1:0] AgeMax          = '1;
  localparam logic [AgeW-1:0] DebounceReset   = 16'd500;

  // hold tiers and the click interval for each
  localparam logic [AgeW-1:0] HoldTier4       = 16'd40000;
  localparam logic [AgeW-1:0] HoldTier3       = 16'd20000;
  localparam logic [AgeW-1:0] HoldTier2       = 16'd10000;
  localparam logic [AgeW-1:0] HoldTier1       = 16'd5000;
  localparam logic [AgeW-1:0] ClickGap4       = 16'd1000;
  localparam logic [AgeW-1:0] ClickGap3       = 16'd2000;
  localparam logic [AgeW-1:0] ClickGap2       = 16'd3000;
  localparam logic [AgeW-1:0] ClickGap1       = 16'd4000;

  // bit positions in the packed pin word
  localparam int unsigned BitMinUp    = 10;
  localparam int unsigned BitMinDown  = 9;
  localparam int unsigned BitSecUp    = 8;
  localparam int unsigned BitSecDown  = 7;
  localparam int unsigned BitReset    = 6;
  localparam int unsigned BitStart    = 5;
  localparam int unsigned BitBypass   = 4;

  typedef logic [WordW-1:0] word_t;

  typedef struct packed {
    logic       min_up;
    logic       min_dn;
    logic       sec_up;
    logic       sec_dn;
    logic       reset;
    logic       run_pause;
    logic       bypass;
    logic [3:0] program_code;
    logic       repeat_click;
  } status_t;

  // saturating increment of an age counter
  function automatic logic [AgeW-1:0] age_inc(input logic [AgeW-1:0] a);
    return (a == AgeMax) ? a : a + 1'b1;
  endfunction

endpackage

[hw/rtl/bda_core.sv]
// ----------------------------------------------------------------------------
// bda_core
// Age counters, debounce threshold and auto-repeat logic. Computes the
// status of one tick from the sampled word and commits the state on advance.
// ----------------------------------------------------------------------------
module bda_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [15:0]      cfg_wdata_i,
  input  logic             advance_i,
  input  bda_pkg::word_t   word_i,
  output bda_pkg::status_t status_o
);
  import bda_pkg::*;

  logic [AgeW-1:0] debounce_q;
  word_t           word_q;
  logic            bypass_level_q;
  logic [AgeW-1:0] bypass_age_q, bypass_age_d;
  logic [AgeW-1:0] stable_age_q, stable_age_d;
  logic [AgeW-1:0] click_age_q,  click_age_d;
  logic [AgeW-1:0] click_inc;
  logic            byp;
  logic            stable;
  logic            tier_on;
  logic [AgeW-1:0] gap;
  logic            click;

  // age updates for this tick
  assign byp          = word_i[BitBypass];
  assign bypass_age_d = (byp != bypass_level_q) ? '0 : age_inc(bypass_age_q);
  assign stable_age_d = (word_i != word_q) ? '0 : age_inc(stable_age_q);
  assign stable       = (stable_age_d >= debounce_q);

  // repeat interval by hold tier
  always_comb begin
    tier_on = 1'b1;
    if (stable_age_d >= HoldTier4) begin
      gap = ClickGap4;
    end else if (stable_age_d >= HoldTier3) begin
      gap = ClickGap3;
    end else if (stable_age_d >= HoldTier2) begin
      gap = ClickGap2;
    end else if (stable_age_d >= HoldTier1) begin
      gap = ClickGap1;
    end else begin
      gap     = AgeMax;
      tier_on = 1'b0;
    end
  end

  assign click_inc   = age_inc(click_age_q);
  assign click       = tier_on && (click_inc > gap);
  assign click_age_d = click ? '0 : click_inc;

  // status of this tick
  always_comb begin
    status_o.min_up       = stable & word_i[BitMinUp];
    status_o.min_dn       = stable & word_i[BitMinDown];
    status_o.sec_up       = stable & word_i[BitSecUp];
    status_o.sec_dn       = stable & word_i[BitSecDown];
    status_o.reset        = stable & word_i[BitReset];
    status_o.run_pause    = stable & word_i[BitStart];
    status_o.bypass       = (bypass_age_d > debounce_q) ? byp : (stable & byp);
    status_o.program_code = word_i[3:0];
    status_o.repeat_click = click;
  end

  // debounce time register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DebounceReset;
    end else if (cfg_we_i) begin
      debounce_q <= cfg_wdata_i;
    end
  end

  // state commit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q         <= '0;
      bypass_level_q <= 1'b0;
      bypass_age_q   <= '0;
      stable_age_q   <= '0;
      click_age_q    <= '0;
    end else if (advance_i) begin
      word_q         <= word_i;
      bypass_level_q <= byp;
      bypass_age_q   <= bypass_age_d;
      stable_age_q   <= stable_age_d;
      click_age_q    <= click_age_d;
    end
  end

endmodule

[hw/rtl/button_debounce_autorepeat.sv]
// ----------------------------------------------------------------------------
// button_debounce_autorepeat
// Debounces the timer buttons of four raw port bytes and produces
// auto-repeat clicks that speed up with hold time.
//
//   channel  signals                      direction  meaning
//   in       in_valid_i / in_ready_o      in         one sample tick
//   out      out_valid_o / out_ready_i    out        status of one tick
//   cfg      cfg_we_i / cfg_wdata_i       in         debounce time
//
// One tick per cycle unless a result stalls; input register, then result
// register. The counters and compares sit in one stage between them.
// Reset clears all ages and the word, and loads a debounce time of 500.
// A stalled result holds the result register; the input register still
// takes a tick while it is empty, or while the result register is free or
// being drained.
// ----------------------------------------------------------------------------
module button_debounce_autorepeat (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  port_a_i,
  input  logic [7:0]  port_b_i,
  input  logic [7:0]  port_c_i,
  input  logic [7:0]  port_e_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        min_up_pressed_o,
  output logic        min_down_pressed_o,
  output logic        sec_up_pressed_o,
  output logic        sec_down_pressed_o,
  output logic        reset_pressed_o,
  output logic        start_pause_pressed_o,
  output logic        bypass_pressed_o,
  output logic [3:0]  program_code_o,
  output logic        repeat_click_o
);
  import bda_pkg::*;

  logic    in_valid_q;
  word_t   in_word_q;
  logic    out_valid_q;
  status_t out_q;
  status_t status;
  logic    advance;
  logic    in_take;

  // stage handshake
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  // input register: pack the pins of interest
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_word_q <= {port_c_i[3:2], port_a_i[5:4], port_e_i[2:0], port_b_i[5:2]};
    end
  end

  bda_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .advance_i  (advance),
    .word_i     (in_word_q),
    .status_o   (status)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= status;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign min_up_pressed_o      = out_q.min_up;
  assign min_down_pressed_o    = out_q.min_dn;
  assign sec_up_pressed_o      = out_q.sec_up;
  assign sec_down_pressed_o    = out_q.sec_dn;
  assign reset_pressed_o       = out_q.reset;
  assign start_pause_pressed_o = out_q.run_pause;
  assign bypass_pressed_o      = out_q.bypass;
  assign program_code_o        = out_q.program_code;
  assign repeat_click_o        = out_q.repeat_click;

endmodule

[hw/rtl/bda_checker.sv]
// ----------------------------------------------------------------------------
// bda_checker
// Port-level checks for the button debouncer, attached to the top level.
// ----------------------------------------------------------------------------
module bda_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       repeat_click_o,
  input logic [3:0] program_code_o
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(repeat_click_o) && $stable(program_code_o))
    else $error("stalled result changed");

  // input only stalls behind a full, stalled result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without backpressure");

  // a fresh result follows an input transaction via input and result registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without input transaction");

  // a click restarts the interval, so back-to-back transactions never both click
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && repeat_click_o ##1 out_valid_o && out_ready_i
      |-> !repeat_click_o)
    else $error("two consecutive repeat clicks");

endmodule

bind button_debounce_autorepeat bda_checker u_bda_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .repeat_click_o(repeat_click_o),
  .program_code_o(program_code_o)
);

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for button_debounce_autorepeat. Port bytes are driven
// as input transactions through the valid/ready handshake. A behavioral
// predictor kept in step with the block works out the status of each tick,
// and every result transaction is checked field by field against it. Test
// tasks cover directed corner cases, random hold runs under several debounce
// times, back-pressure, and bypass held on under a changing word.
// ----------------------------------------------------------------------------
module testbench;
  import bda_pkg::*;

  // pins of each port that reach the packed word
  localparam logic [7:0] AUsed = 8'h30;
  localparam logic [7:0] BUsed = 8'h3C;
  localparam logic [7:0] CUsed = 8'h0C;
  localparam logic [7:0] EUsed = 8'h07;

  localparam int unsigned PhaseLen   = 300;
  localparam int unsigned MaxReports = 10;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        cfg_we_i     = 1'b0;
  logic [15:0] cfg_wdata_i  = '0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic [7:0]  port_a_i     = '0;
  logic [7:0]  port_b_i     = '0;
  logic [7:0]  port_c_i     = '0;
  logic [7:0]  port_e_i     = '0;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic        min_up_pressed_o;
  logic        min_down_pressed_o;
  logic        sec_up_pressed_o;
  logic        sec_down_pressed_o;
  logic        reset_pressed_o;
  logic        start_pause_pressed_o;
  logic        bypass_pressed_o;
  logic [3:0]  program_code_o;
  logic        repeat_click_o;

  // predictor state
  logic [AgeW-1:0] debounce_len = DebounceReset;
  word_t           pin_word     = '0;
  logic            bypass_level = 1'b0;
  logic [AgeW-1:0] bypass_age   = '0;
  logic [AgeW-1:0] hold_age     = '0;
  logic [AgeW-1:0] click_age    = '0;

  status_t     pending_status_q[$];
  status_t     want_status;
  int unsigned error_cnt    = 0;
  int unsigned accepted_cnt = 0;
  int unsigned result_cnt   = 0;
  int unsigned stall_left   = 0;

  button_debounce_autorepeat i_dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_wdata_i           (cfg_wdata_i),
    .in_valid_i            (in_valid_i),
    .in_ready_o            (in_ready_o),
    .port_a_i              (port_a_i),
    .port_b_i              (port_b_i),
    .port_c_i              (port_c_i),
    .port_e_i              (port_e_i),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .min_up_pressed_o      (min_up_pressed_o),
    .min_down_pressed_o    (min_down_pressed_o),
    .sec_up_pressed_o      (sec_up_pressed_o),
    .sec_down_pressed_o    (sec_down_pressed_o),
    .reset_pressed_o       (reset_pressed_o),
    .start_pause_pressed_o (start_pause_pressed_o),
    .bypass_pressed_o      (bypass_pressed_o),
    .program_code_o        (program_code_o),
    .repeat_click_o        (repeat_click_o)
  );

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("FAIL button_debounce_autorepeat");
    $finish;
  end

  // idle percentages, rotating every few hundred transactions
  function automatic int unsigned sender_idle_pct();
    case ((accepted_cnt / PhaseLen) % 4)
      1: return 56;
      3: return 16;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned receiver_stall_pct();
    case ((accepted_cnt / PhaseLen) % 4)
      2: return 56;
      3: return 16;
      default: return 0;
    endcase
  endfunction

  function automatic logic [AgeW-1:0] age_step(input logic [AgeW-1:0] v);
    return (v == AgeMax) ? v : v + 1'b1;
  endfunction

  // random values on the pins the block ignores
  function automatic logic [7:0] mix_spare(input logic [7:0] v, input logic [7:0] used);
    logic [7:0] r;
    r = 8'($urandom);
    return (v & used) | (r & ~used);
  endfunction

  // status of one tick; advances the predictor state
  task automatic compute_status(input logic [7:0] a, b, c, e, output status_t st);
    word_t           w;
    logic            stable;
    logic            tier_hit;
    logic [AgeW-1:0] gap;
    w = {c[3:2], a[5:4], e[2:0], b[5:2]};
    if (w[BitBypass] != bypass_level) begin
      bypass_level = w[BitBypass];
      bypass_age   = '0;
    end else begin
      bypass_age = age_step(bypass_age);
    end
    if (w == pin_word) begin
      hold_age = age_step(hold_age);
    end else begin
      pin_word = w;
      hold_age = '0;
    end
    stable = (hold_age >= debounce_len);
    st.min_up       = stable & pin_word[BitMinUp];
    st.min_dn       = stable & pin_word[BitMinDown];
    st.sec_up       = stable & pin_word[BitSecUp];
    st.sec_dn       = stable & pin_word[BitSecDown];
    st.reset        = stable & pin_word[BitReset];
    st.run_pause    = stable & pin_word[BitStart];
    st.bypass       = (bypass_age > debounce_len) ? bypass_level
                                                  : (stable & pin_word[BitBypass]);
    st.program_code = pin_word[3:0];
    // repeat interval shrinks with hold time
    click_age = age_step(click_age);
    tier_hit  = 1'b1;
    gap       = '0;
    if (hold_age >= HoldTier4) begin
      gap = ClickGap4;
    end else if (hold_age >= HoldTier3) begin
      gap = ClickGap3;
    end else if (hold_age >= HoldTier2) begin
      gap = ClickGap2;
    end else if (hold_age >= HoldTier1) begin
      gap = ClickGap1;
    end else begin
      tier_hit = 1'b0;
    end
    st.repeat_click = tier_hit && (click_age > gap);
    if (st.repeat_click) begin
      click_age = '0;
    end
  endtask

  // one input transaction, with random idle cycles ahead of it
  task automatic send_tick(input logic [7:0] a, b, c, e);
    int unsigned pct;
    status_t     st;
    pct = sender_idle_pct();
    @(negedge clk_i);
    while ($urandom_range(99) < pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    port_a_i   <= a;
    port_b_i   <= b;
    port_c_i   <= c;
    port_e_i   <= e;
    do @(posedge clk_i); while (!in_ready_o);
    compute_status(a, b, c, e, st);
    pending_status_q.push_back(st);
    accepted_cnt++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_status_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_debounce(input logic [15:0] ticks);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= ticks;
    @(negedge clk_i);
    cfg_we_i     <= 1'b0;
    debounce_len  = ticks;
  endtask

  task automatic flag_error(input string msg);
    error_cnt++;
    if (error_cnt <= MaxReports) begin
      $display("result %0d: %s", result_cnt, msg);
    end
  endtask

  task automatic check_field(input string fname, input logic [3:0] want, input logic [3:0] got);
    if (got !== want) begin
      flag_error($sformatf("%s expected %0d, got %0d", fname, want, got));
    end
  endtask

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= receiver_stall_pct());
    end
  end

  // compare each result transaction with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_status_q.size() == 0) begin
        flag_error("result with no prediction waiting");
      end else begin
        want_status = pending_status_q.pop_front();
        check_field("min_up", 4'(want_status.min_up), 4'(min_up_pressed_o));
        check_field("min_dn", 4'(want_status.min_dn), 4'(min_down_pressed_o));
        check_field("sec_up", 4'(want_status.sec_up), 4'(sec_up_pressed_o));
        check_field("sec_dn", 4'(want_status.sec_dn), 4'(sec_down_pressed_o));
        check_field("reset", 4'(want_status.reset), 4'(reset_pressed_o));
        check_field("run_pause", 4'(want_status.run_pause), 4'(start_pause_pressed_o));
        check_field("bypass", 4'(want_status.bypass), 4'(bypass_pressed_o));
        check_field("program_code", want_status.program_code, program_code_o);
        check_field("repeat_click", 4'(want_status.repeat_click), 4'(repeat_click_o));
      end
      result_cnt++;
    end
  end

  // corner cases under the reset debounce time, zero and one
  task automatic test_directed();
    send_tick(8'h00, 8'h00, 8'h00, 8'h00);
    send_tick(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_tick(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_tick(8'hCF, 8'hC3, 8'hF3, 8'hF8);
    send_tick(AUsed, BUsed, CUsed, EUsed);
    set_debounce(16'd0);
    send_tick(8'h00, 8'h00, 8'h00, 8'h00);
    send_tick(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_tick(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_tick(8'h00, 8'h00, 8'h00, 8'h01);
    send_tick(8'h00, 8'h00, 8'h00, 8'h01);
    send_tick(8'h00, 8'h00, 8'h00, 8'h00);
    send_tick(8'h10, 8'h04, 8'h08, 8'h02);
    set_debounce(16'd1);
    send_tick(8'h20, 8'h38, 8'h04, 8'h05);
    send_tick(8'h20, 8'h38, 8'h04, 8'h05);
    send_tick(8'hE0, 8'hB8, 8'hF4, 8'hFD);
    send_tick(8'h20, 8'h38, 8'h04, 8'h04);
    send_tick(8'h20, 8'h38, 8'h04, 8'h04);
    send_tick(8'h20, 8'h38, 8'h04, 8'h04);
  endtask

  // mostly hold runs with random content, some noise ticks
  task automatic test_random_runs();
    logic [15:0] deb_set[5];
    int unsigned cap;
    int unsigned run_len;
    int unsigned kind;
    int unsigned sent;
    logic [7:0]  a, b, c, e;
    deb_set    = '{16'd3, 16'd0, 16'd1, 16'd0, 16'hFFFF};
    deb_set[3] = 16'($urandom_range(40, 2));
    foreach (deb_set[k]) begin
      set_debounce(deb_set[k]);
      cap  = (deb_set[k] > 60) ? 124 : 2 * deb_set[k] + 4;
      sent = 0;
      while (sent < 230) begin
        kind = $urandom_range(9);
        a = 8'($urandom);
        b = 8'($urandom);
        c = 8'($urandom);
        e = 8'($urandom);
        if (kind < 2) begin
          send_tick(a, b, c, e);
          sent++;
        end else begin
          run_len = $urandom_range(cap, 1);
          repeat (run_len) begin
            // word moves under a steady bypass
            if (kind == 2 && $urandom_range(3) == 0) a[4] = ~a[4];
            // bypass flicker
            if (kind == 3 && $urandom_range(7) == 0) e[0] = ~e[0];
            send_tick(mix_spare(a, AUsed), mix_spare(b, BUsed),
                      mix_spare(c, CUsed), mix_spare(e, EUsed));
            sent++;
          end
        end
      end
    end
  endtask

  // long receiver hold-off fills the block, then a full drain mid-stream
  task automatic test_backpressure();
    set_debounce(16'd2);
    stall_left = 80;
    repeat (30) send_tick(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    wait_drained();
    repeat (20) send_tick(8'h30, 8'h3C, 8'h0C, 8'h07);
  endtask

  // bypass held on under a changing word, then all pins held under the longest time
  task automatic test_long_hold();
    int unsigned i;
    logic [7:0]  e_pins;
    set_debounce(16'd25);
    // bypass held on; ports A and C change every tick, ports B and E every 40 ticks
    e_pins = 8'h01;
    for (i = 0; i < 80; i++) begin
      if (i % 40 == 0) e_pins = {5'b0, 2'($urandom), 1'b1};
      send_tick(mix_spare(8'($urandom), AUsed),
                mix_spare({2'b0, 4'(i / 40), 2'b0}, BUsed),
                mix_spare(8'($urandom), CUsed), mix_spare(e_pins, EUsed));
    end
    set_debounce(16'hFFFF);
    for (i = 0; i < 60; i++) begin
      send_tick(mix_spare(AUsed, AUsed), mix_spare(BUsed, BUsed),
                mix_spare(CUsed, CUsed), mix_spare(EUsed, EUsed));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random_runs();
    test_backpressure();
    test_long_hold();
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (error_cnt == 0 && pending_status_q.size() == 0) begin
      $display("PASS button_debounce_autorepeat");
    end else begin
      $display("FAIL button_debounce_autorepeat");
    end
    $finish;
  end

endmodule
